@@ sv/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter package
// Field widths, default sizes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Port field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned RadixW = 16;
  localparam int unsigned CountW = 6;
  localparam int unsigned DigitW = 16;

  // Default sizes
  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned MaxDigitsDef = 32;

  // Smallest usable base
  localparam logic [RadixW-1:0] MinRadix = RadixW'(2);

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // latch a new item, clear the divider and index
    logic div_step;  // one restoring division step
    logic store;     // write the remainder as the next digit
    logic err;       // load the error result into the output register
    logic rd;        // read the next digit (most significant first)
    logic pop;       // step the read index down after a delivered digit
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_last;   // this step finishes the current division
    logic quot_zero;  // quotient left after the division is zero
    logic at_limit;   // the digit being stored is the last one allowed
    logic min_mode;   // item asked for the minimal digit count
    logic out_last;   // result held in the output register ends the item
  } status_t;

endpackage

@@ sv/rdc_datapath.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter datapath
// Serial restoring divider, digit store and output payload registers.
// ----------------------------------------------------------------------------
module rdc_datapath #(
  parameter int unsigned VALUE_BITS = rdc_pkg::ValueBitsDef,
  parameter int unsigned MAX_DIGITS = rdc_pkg::MaxDigitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rdc_pkg::ValueW-1:0]  value_i,
  input  logic [rdc_pkg::RadixW-1:0]  radix_i,
  input  logic [rdc_pkg::CountW-1:0]  digit_count_i,
  input  rdc_pkg::cmd_t               cmd_i,
  output rdc_pkg::status_t            status_o,
  output logic [rdc_pkg::DigitW-1:0]  digit_o,
  output logic                        too_small_o
);
  import rdc_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_DIGITS);
  localparam int unsigned CW   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BW   = $clog2(VALUE_BITS);
  localparam int unsigned ReqW = CountW + 1;
  localparam logic [ReqW-1:0] MaxReq  = ReqW'(MAX_DIGITS);
  localparam logic [BW-1:0]   LastBit = BW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] dvd_q;
  logic [RadixW-1:0]     rem_q;
  logic [RadixW-1:0]     base_q;
  logic [BW-1:0]         bit_q;
  logic [CW-1:0]         idx_q;
  logic [CW-1:0]         limit_q;
  logic                  min_mode_q;
  logic                  last_q;
  logic [DigitW-1:0]     rd_data_q;
  logic                  too_small_q;
  logic [DigitW-1:0]     mem [MAX_DIGITS];

  logic [RadixW:0]       rem_sh;
  logic [RadixW:0]       trial;
  logic                  fits;
  logic [CW-1:0]         idx_inc;
  logic [CW-1:0]         idx_m1;
  logic [ReqW-1:0]       req_ext;
  logic [CW-1:0]         limit_d;
  logic                  div_last;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh   = {rem_q, dvd_q[VALUE_BITS-1]};
  assign trial    = rem_sh - {1'b0, base_q};
  assign fits     = ~trial[RadixW];
  assign idx_inc  = idx_q + CW'(1);
  assign idx_m1   = idx_q - CW'(1);
  assign div_last = (bit_q == LastBit);

  assign req_ext = {1'b0, digit_count_i};
  always_comb begin
    if (req_ext == '0 || req_ext > MaxReq) begin
      limit_d = CW'(MAX_DIGITS);
    end else begin
      limit_d = req_ext[CW-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q      <= '0;
      idx_q      <= '0;
      limit_q    <= '0;
      min_mode_q <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        bit_q      <= '0;
        idx_q      <= '0;
        limit_q    <= limit_d;
        min_mode_q <= (digit_count_i == '0);
      end
      if (cmd_i.div_step) begin
        bit_q <= div_last ? '0 : bit_q + BW'(1);
      end
      if (cmd_i.store) begin
        idx_q <= idx_inc;
      end
      if (cmd_i.pop) begin
        idx_q <= idx_m1;
      end
      if (cmd_i.err) begin
        last_q <= 1'b1;
      end
      if (cmd_i.rd) begin
        last_q <= (idx_q == CW'(1));
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvd_q  <= VALUE_BITS'(value_i);
      rem_q  <= '0;
      base_q <= (radix_i < MinRadix) ? MinRadix : radix_i;
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[VALUE_BITS-2:0], fits};
      rem_q <= fits ? trial[RadixW-1:0] : rem_sh[RadixW-1:0];
    end
    if (cmd_i.store) begin
      rem_q <= '0;
    end
    if (cmd_i.err) begin
      rd_data_q   <= '0;
      too_small_q <= 1'b1;
    end
    if (cmd_i.rd) begin
      rd_data_q   <= mem[idx_m1[AW-1:0]];
      too_small_q <= 1'b0;
    end
  end

  // Digit store, least significant digit at entry zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[idx_q[AW-1:0]] <= DigitW'(rem_q);
    end
  end

  assign status_o.div_last  = div_last;
  assign status_o.quot_zero = (dvd_q == '0);
  assign status_o.at_limit  = (idx_inc == limit_q);
  assign status_o.min_mode  = min_mode_q;
  assign status_o.out_last  = last_q;

  assign digit_o     = rd_data_q;
  assign too_small_o = too_small_q;

endmodule

@@ sv/rdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter controller
// Sequences division, digit storage and digit delivery for one item.
// ----------------------------------------------------------------------------
module rdc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rdc_pkg::status_t   status_i,
  output rdc_pkg::cmd_t      cmd_o
);
  import rdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_READ,
    S_SEND
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   conv_done;

  assign conv_done = (status_i.min_mode && status_i.quot_zero) || status_i.at_limit;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:  cmd_o.load     = in_valid_i;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_STORE: begin
        cmd_o.store = 1'b1;
        cmd_o.err   = conv_done && !status_i.quot_zero;
      end
      S_READ:  cmd_o.rd       = 1'b1;
      S_SEND:  cmd_o.pop      = out_ready_i && !status_i.out_last;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_ready_q <= 1'b0;
            state_q    <= S_DIV;
          end
        end
        S_DIV: begin
          if (status_i.div_last) begin
            state_q <= S_STORE;
          end
        end
        S_STORE: begin
          if (!conv_done) begin
            state_q <= S_DIV;
          end else if (status_i.quot_zero) begin
            state_q <= S_READ;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= S_SEND;
          end
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          state_q     <= S_SEND;
        end
        S_SEND: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (status_i.out_last) begin
              in_ready_q <= 1'b1;
              state_q    <= S_IDLE;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/radix_digit_converter_top.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter
// Emits the digits of an unsigned value in a given base, most significant
// first, with the final digit of each item marked.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A digit costs one division by the base
// on a bit-serial restoring divider, plus a step to store it; after all
// digits are produced, each is read from the digit store and presented on
// the output. A count of zero asks for the minimal number of digits; a
// nonzero count pads with leading zeros, and is held at MAX_DIGITS if
// larger. When the count cannot hold the value, a single item with digit
// zero, last and too_small set is given instead. A base below two is
// treated as two. Only the low VALUE_BITS bits of the value are used.
// ----------------------------------------------------------------------------
module radix_digit_converter_top #(
  parameter int unsigned VALUE_BITS = rdc_pkg::ValueBitsDef,
  parameter int unsigned MAX_DIGITS = rdc_pkg::MaxDigitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input item channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rdc_pkg::ValueW-1:0]  value_i,
  input  logic [rdc_pkg::RadixW-1:0]  radix_i,
  input  logic [rdc_pkg::CountW-1:0]  digit_count_i,
  // Result item channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rdc_pkg::DigitW-1:0]  digit_o,
  output logic                        last_o,
  output logic                        too_small_o
);
  import rdc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: divide, store, then hand digits out one item at a time
  rdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Divider, digit store and output payload
  rdc_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .radix_i       (radix_i),
    .digit_count_i (digit_count_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .digit_o       (digit_o),
    .too_small_o   (too_small_o)
  );

  // The last flag is held in the datapath alongside the digit
  assign last_o = status.out_last;

endmodule
